@@ rtl/file_uri_percent_decoder_macros.svh @@
// assertion macros shared by the checker of the uri decoder
`ifndef FILE_URI_PERCENT_DECODER_MACROS_SVH
`define FILE_URI_PERCENT_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define FUPD_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("uri decoder check failed");

// next-cycle implication, sampled on clk, quiet in reset
`define FUPD_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("uri decoder check failed");

`endif

@@ rtl/fupd_pkg.sv @@
// shared types, constants and character helpers of the uri percent decoder
`timescale 1ns / 1ps
`default_nettype none
package fupd_pkg;

	localparam int unsigned PREFIX_LEN  = 7;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] PERCENT_CHAR = 8'h25;

	// held escape codes
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_PCT  = 2'd1;
	localparam logic [1:0] HELD_HEX  = 2'd2;

	// one classified input byte: up to three results
	typedef struct packed {
		logic [1:0] cnt;       // number of results, 1..3
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       present;   // 0 only for the lone empty closing result
		logic       path_end;  // last result of this entry closes the path
		logic       path_kept;
	} fupd_entry_t;

	// front to queue
	typedef struct packed {
		logic        valid;
		fupd_entry_t entry;
	} fupd_push_t;

	// queue to back
	typedef struct packed {
		logic        empty;
		fupd_entry_t head;
	} fupd_head_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (pos)
			3'd0: c = 8'h66; // f
			3'd1: c = 8'h69; // i
			3'd2: c = 8'h6c; // l
			3'd3: c = 8'h65; // e
			3'd4: c = 8'h3a; // :
			3'd5: c = 8'h2f; // /
			3'd6: c = 8'h2f; // /
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) ||
		       ((c >= 8'h61) && (c <= 8'h66)) ||
		       ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	// nibble value of a hex digit, zero for anything else
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			v = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			v = c - 8'h57;
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/fupd_front.sv @@
// front end: prefix match, escape tracking and classification of each byte
`timescale 1ns / 1ps
`default_nettype none
module fupd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_byte,
	input  wire logic               in_last,
	input  wire logic               queue_full,
	output fupd_pkg::fupd_push_t    push
);

	logic [2:0] pos_q;
	logic       failed_q;
	logic [1:0] held_q;
	logic [7:0] hex_q;
	logic       emitted_q;

	logic [2:0] pos_d;
	logic       failed_d;
	logic [1:0] held_d;
	logic [7:0] hex_d;
	logic       emitted_d;
	logic       accept;

	fupd_pkg::fupd_entry_t ent;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pos_d     = pos_q;
		failed_d  = failed_q;
		held_d    = held_q;
		hex_d     = hex_q;
		ent       = '0;
		ent.present = 1'b1;

		if (failed_q) begin
			// dropped uri, wait for its end
		end else if (pos_q != 3'(fupd_pkg::PREFIX_LEN)) begin
			if (in_byte == fupd_pkg::prefix_char(pos_q)) begin
				pos_d = pos_q + 3'd1;
			end else begin
				failed_d = 1'b1;
			end
		end else begin
			unique case (held_q)
				fupd_pkg::HELD_PCT: begin
					if (fupd_pkg::is_hex(in_byte) && !in_last) begin
						hex_d  = in_byte;
						held_d = fupd_pkg::HELD_HEX;
					end else begin
						held_d  = fupd_pkg::HELD_NONE;
						ent.b0  = fupd_pkg::PERCENT_CHAR;
						ent.cnt = 2'd1;
						if (in_byte == fupd_pkg::PERCENT_CHAR && !in_last) begin
							held_d = fupd_pkg::HELD_PCT;
						end else begin
							ent.b1  = in_byte;
							ent.cnt = 2'd2;
						end
					end
				end
				fupd_pkg::HELD_HEX: begin
					held_d = fupd_pkg::HELD_NONE;
					if (fupd_pkg::is_hex(in_byte)) begin
						ent.b0  = {fupd_pkg::hex_val(hex_q), fupd_pkg::hex_val(in_byte)};
						ent.cnt = 2'd1;
					end else begin
						ent.b0  = fupd_pkg::PERCENT_CHAR;
						ent.b1  = hex_q;
						ent.cnt = 2'd2;
						if (in_byte == fupd_pkg::PERCENT_CHAR && !in_last) begin
							held_d = fupd_pkg::HELD_PCT;
						end else begin
							ent.b2  = in_byte;
							ent.cnt = 2'd3;
						end
					end
				end
				default: begin
					// no escape open; an unused held code acts as none
					held_d = fupd_pkg::HELD_NONE;
					if (in_byte == fupd_pkg::PERCENT_CHAR && !in_last) begin
						held_d = fupd_pkg::HELD_PCT;
					end else begin
						ent.b0  = in_byte;
						ent.cnt = 2'd1;
					end
				end
			endcase
		end

		emitted_d = emitted_q || (ent.cnt != 2'd0);

		if (in_last) begin
			ent.path_end  = 1'b1;
			ent.path_kept = !failed_d && (pos_d == 3'(fupd_pkg::PREFIX_LEN)) && emitted_d;
			if (ent.cnt == 2'd0) begin
				ent.cnt     = 2'd1;
				ent.present = 1'b0;
			end
			// back to reset state for the next uri
			pos_d     = 3'd0;
			failed_d  = 1'b0;
			held_d    = fupd_pkg::HELD_NONE;
			hex_d     = 8'h00;
			emitted_d = 1'b0;
		end
	end

	assign push.valid = accept && (ent.cnt != 2'd0);
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			failed_q  <= 1'b0;
			held_q    <= fupd_pkg::HELD_NONE;
			hex_q     <= 8'h00;
			emitted_q <= 1'b0;
		end else if (accept) begin
			pos_q     <= pos_d;
			failed_q  <= failed_d;
			held_q    <= held_d;
			hex_q     <= hex_d;
			emitted_q <= emitted_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/fupd_queue.sv @@
// small fifo of classified entries between front and back
`timescale 1ns / 1ps
`default_nettype none
module fupd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  fupd_pkg::fupd_push_t      push,
	input  wire logic                 pop,
	output logic                      full,
	output fupd_pkg::fupd_head_t      head
);

	localparam int unsigned AW = fupd_pkg::QUEUE_AW;

	fupd_pkg::fupd_entry_t mem_q [fupd_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == (AW+1)'(fupd_pkg::QUEUE_DEPTH));
	assign head.empty = (count_q == '0);
	assign head.head  = mem_q[rd_ptr_q];

	assign do_push = push.valid && !full;
	assign do_pop  = pop && !head.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// depth is a power of two, so the pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/fupd_back.sv @@
// back end: walks each entry one result per cycle, unless the output stalls, into the output register
`timescale 1ns / 1ps
`default_nettype none
module fupd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  fupd_pkg::fupd_head_t    head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_byte,
	output logic                    out_present,
	output logic                    out_end,
	output logic                    out_kept
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       end_q;
	logic       kept_q;

	logic       load;
	logic       is_final;
	logic [7:0] sel_byte;

	assign load     = !head.empty && (!valid_q || out_ready);
	assign is_final = (idx_q == (head.head.cnt - 2'd1));
	assign pop      = load && is_final;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head.head.b0;
			2'd1:    sel_byte = head.head.b1;
			default: sel_byte = head.head.b2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= sel_byte;
			present_q <= head.head.present;
			end_q     <= head.head.path_end && is_final;
			kept_q    <= head.head.path_kept && is_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_final ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign out_present = present_q;
	assign out_end     = end_q;
	assign out_kept    = kept_q;

endmodule
`default_nettype wire

@@ rtl/file_uri_percent_decoder.sv @@
// top level of the file uri percent decoder
`timescale 1ns / 1ps
`default_nettype none
// file uri percent decoder. takes a uri one byte per request on the slave
// stream, tlast on its final byte. the first seven bytes must read "file://";
// otherwise the uri produces no path bytes. after the prefix, '%' and two hex
// digits of either case become one byte; a broken or cut-off escape comes out
// literally. every byte turns into zero to three result requests, and the
// uri's last byte always closes with a result that has tlast set: tuser[1]
// tells whether the path is kept (prefix matched and at least one byte came
// out). an empty result (tuser[0] low, tdata zero) carries tlast when the last
// byte yields no path byte.
// rate: the front accepts one byte per cycle whenever the four-entry queue has
// room; the back emits one result per cycle while m_axis_tready is high. a byte
// yields 1 to 3 results (none for prefix bytes and held escape characters,
// except on the uri's last byte). sustained throughput is one result per cycle
// while m_axis_tready is high, set by the single output register. the first
// result of a byte passes through the queue and then the output register
// before it appears on the master side. there is no clearing pass after reset.
module file_uri_percent_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input byte stream
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] uri_byte
	input  wire logic       s_axis_tlast,  // uri_last
	// decoded path stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] path_byte
	output logic            m_axis_tlast,  // path_end
	output logic [1:0]      m_axis_tuser   // [0] byte_present, [1] path_kept
);

	fupd_pkg::fupd_push_t push;
	fupd_pkg::fupd_head_t head;
	logic                 queue_full;
	logic                 pop;
	logic                 present;
	logic                 kept;

	// front: prefix check and escape state, one entry per byte with results
	fupd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.queue_full (queue_full),
		.push       (push)
	);

	// decouples bursts of up to three results from the input, which takes one byte per cycle while the queue has room
	fupd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (queue_full),
		.head   (head)
	);

	// back: serializes entries and holds the output register
	fupd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.out_present (present),
		.out_end     (m_axis_tlast),
		.out_kept    (kept)
	);

	assign m_axis_tuser = {kept, present};

endmodule
`default_nettype wire

@@ rtl/fupd_checker.sv @@
// port-level checker of the uri decoder and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "file_uri_percent_decoder_macros.svh"
module fupd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast,
	input wire logic [1:0] m_axis_tuser
);

	logic        in_req;
	logic        out_stall;
	logic [10:0] out_word;
	logic        quiet;
	logic        seen;

	assign in_req    = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
	assign quiet     = !in_req && !m_axis_tvalid;
	assign seen      = m_axis_tvalid || in_req;

	// a stalled result holds
	`FUPD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
	// an empty result carries only the end of the path
	`FUPD_ASSERT_NOW(a_empty_is_end, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && !m_axis_tuser[1] && (m_axis_tdata == 8'h00))
	// kept is reported only on the closing result
	`FUPD_ASSERT_NOW(a_kept_on_end, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
	// a result cannot appear before any byte came in
	`FUPD_ASSERT_NEXT(a_no_early_out, quiet && !$past(in_req), !m_axis_tvalid || $past(seen, 2))

endmodule

bind file_uri_percent_decoder fupd_checker u_fupd_checker (.*);
`default_nettype wire
